/* design/pulldown_field_mapper_core_macros.svh */
// ----------------------------------------------------------------------------
// Pulldown field mapper assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef PULLDOWN_FIELD_MAPPER_CORE_MACROS_SVH
`define PULLDOWN_FIELD_MAPPER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pulldown field mapper: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pulldown field mapper: next-cycle check failed");

`endif

/* design/pfm_pkg.sv */
// ----------------------------------------------------------------------------
// Pulldown field mapper package
// Payload types, state and result batch structures, mode codes.
// ----------------------------------------------------------------------------
package pfm_pkg;

  localparam int CNT_W = 20;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_FILM   = 2'd1;
  localparam logic [1:0] MODE_RAW    = 2'd2;

  localparam logic signed [3:0] BAL_MAX     = 4'sd7;
  localparam logic signed [3:0] BAL_MIN     = -4'sd8;
  localparam logic signed [3:0] THR_LOCKED  = 4'sd5;
  localparam logic signed [3:0] THR_SEARCH  = 4'sd3;

  typedef struct packed {
    logic top_first;
    logic repeat_first;
    logic progressive;
  } pfm_in_t;

  typedef struct packed {
    logic [CNT_W-1:0] frame_slot;
    logic             write_top;
    logic             write_bottom;
    logic [CNT_W-1:0] source_picture;
    logic             first_field_order;
    logic             repeats_seen;
    logic             overflow;
    logic             last;
  } pfm_out_t;

  typedef struct packed {
    logic [CNT_W-1:0]  picture_count;
    logic [CNT_W-1:0]  slot_count;
    logic signed [3:0] repeat_balance;
    logic              film_locked;
    logic              top_pending;
    logic              bottom_pending;
    logic              repeats_flag;
    logic              order_flag;
  } pfm_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] slot;
    logic             wr_top;
    logic             wr_bottom;
  } pfm_entry_t;

  typedef struct packed {
    logic [1:0]           count;
    pfm_entry_t [2:0]     entry;
    logic [CNT_W-1:0]     source;
    logic                 order;
    logic                 repeats;
    logic                 overflow;
  } pfm_batch_t;

endpackage

/* design/pfm_step.sv */
// ----------------------------------------------------------------------------
// Pulldown field mapper step logic
// Computes one picture's writes and the next mapper state.
// ----------------------------------------------------------------------------
module pfm_step (
  input  pfm_pkg::pfm_in_t    item,
  input  pfm_pkg::pfm_state_t st,
  input  logic [1:0]          field_mode,
  output pfm_pkg::pfm_state_t st_nxt,
  output pfm_pkg::pfm_batch_t batch
);
  import pfm_pkg::*;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] base,
                                               input logic [1:0] off);
    logic [CNT_W+1:0] sum;
    sum = {2'b00, base} + {{CNT_W{1'b0}}, off};
    if (sum > {2'b00, CNT_MAX}) begin
      return CNT_MAX;
    end
    return sum[CNT_W-1:0];
  endfunction

  logic              film;
  logic              rff;
  logic              tff;
  logic              bal_over;
  logic              slot_over;
  logic              pc_over;
  logic signed [3:0] bal1;
  logic signed [3:0] thr;
  logic signed [3:0] nthr;
  logic              tp;
  logic              bp;
  logic [1:0]        adv;
  logic [1:0]        off [3];
  logic [1:0]        wr  [3];
  logic [CNT_W+1:0]  slot_sum;

  assign film    = (field_mode == MODE_FILM);
  assign rff     = item.repeat_first && (field_mode != MODE_RAW);
  assign tff     = item.top_first;
  assign thr     = st.film_locked ? THR_LOCKED : THR_SEARCH;
  assign nthr    = -thr;
  assign pc_over = (st.picture_count == CNT_MAX);

  always_comb begin
    st_nxt      = st;
    batch.count = 2'd0;
    adv         = 2'd0;
    bal_over    = 1'b0;
    bal1        = st.repeat_balance;
    tp          = st.top_pending;
    bp          = st.bottom_pending;
    for (int i = 0; i < 3; i++) begin
      off[i] = 2'd0;
      wr[i]  = 2'b11;
    end

    if (film) begin
      if (rff) begin
        if (st.repeat_balance >= BAL_MAX) bal_over = 1'b1;
        else bal1 = st.repeat_balance + 4'sd1;
      end else begin
        if (st.repeat_balance <= BAL_MIN) bal_over = 1'b1;
        else bal1 = st.repeat_balance - 4'sd1;
      end
      st_nxt.repeat_balance = bal1;
      if (bal1 == nthr) begin
        // Balance swung the other way: drop this frame.
        st_nxt.repeat_balance = 4'sd0;
        st_nxt.film_locked    = 1'b1;
      end else if (bal1 == thr) begin
        // Too many repeats pending: double this frame.
        st_nxt.repeat_balance = 4'sd0;
        st_nxt.film_locked    = 1'b1;
        batch.count = 2'd2;
        off[1]      = 2'd1;
        adv         = 2'd2;
      end else begin
        batch.count = 2'd1;
        adv         = 2'd1;
      end
    end else if (item.progressive) begin
      batch.count = rff ? (tff ? 2'd3 : 2'd2) : 2'd1;
      off[1]      = 2'd1;
      off[2]      = 2'd2;
      adv         = batch.count;
    end else begin
      adv = 2'd1;
      if (st.top_pending) begin
        batch.count = 2'd2;
        wr[0] = 2'b01;
        wr[1] = 2'b10;
        off[1] = 2'd1;
      end else if (st.bottom_pending) begin
        batch.count = 2'd2;
        wr[0] = 2'b10;
        wr[1] = 2'b01;
        off[1] = 2'd1;
      end else begin
        batch.count = 2'd1;
      end
      if (rff) begin
        // The repeat lands on the next slot and stays pending if unpaired.
        off[batch.count] = 2'd1;
        wr[batch.count]  = tff ? 2'b10 : 2'b01;
        batch.count      = batch.count + 2'd1;
        tp = st.top_pending | tff;
        bp = st.bottom_pending | ~tff;
        if (tp && bp) begin
          tp  = 1'b0;
          bp  = 1'b0;
          adv = 2'd2;
        end
      end
      st_nxt.top_pending    = tp;
      st_nxt.bottom_pending = bp;
    end

    for (int i = 0; i < 3; i++) begin
      batch.entry[i].slot      = sat_add(st.slot_count, off[i]);
      batch.entry[i].wr_top    = wr[i][1];
      batch.entry[i].wr_bottom = wr[i][0];
    end

    // The slot counter holds at its maximum once any advance would pass it.
    slot_sum  = {2'b00, st.slot_count} + {{CNT_W{1'b0}}, adv};
    slot_over = (slot_sum > {2'b00, CNT_MAX});
    st_nxt.slot_count    = slot_over ? CNT_MAX : slot_sum[CNT_W-1:0];
    st_nxt.picture_count = pc_over ? CNT_MAX : st.picture_count + CNT_W'(1);
    st_nxt.repeats_flag  = st.repeats_flag | (!film & rff);
    st_nxt.order_flag    = (st.picture_count == '0) ? tff : st.order_flag;

    batch.source   = st.picture_count;
    batch.order    = st_nxt.order_flag;
    batch.repeats  = st_nxt.repeats_flag;
    batch.overflow = bal_over | slot_over | pc_over;
  end

endmodule

/* design/pfm_drain.sv */
// ----------------------------------------------------------------------------
// Pulldown field mapper result drain
// Holds one picture's batch of writes and presents them one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module pfm_drain (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  pfm_pkg::pfm_batch_t batch_in,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output pfm_pkg::pfm_out_t   out_data
);
  import pfm_pkg::*;

  pfm_batch_t batch_r;
  logic       valid_r;
  logic [1:0] idx_r;
  logic       take;
  logic       is_last;
  pfm_entry_t cur;

  assign take    = valid_r && out_ready;
  assign is_last = (idx_r == 2'(batch_r.count - 2'd1));
  assign free    = !valid_r || (take && is_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= 2'd0;
    end else if (take) begin
      if (is_last) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      batch_r <= batch_in;
    end
  end

  always_comb begin
    case (idx_r)
      2'd0:    cur = batch_r.entry[0];
      2'd1:    cur = batch_r.entry[1];
      default: cur = batch_r.entry[2];
    endcase
  end

  assign out_valid                  = valid_r;
  assign out_data.frame_slot        = cur.slot;
  assign out_data.write_top         = cur.wr_top;
  assign out_data.write_bottom      = cur.wr_bottom;
  assign out_data.source_picture    = batch_r.source;
  assign out_data.first_field_order = batch_r.order;
  assign out_data.repeats_seen      = batch_r.repeats;
  assign out_data.overflow          = batch_r.overflow;
  assign out_data.last              = is_last;

endmodule

/* design/pulldown_field_mapper_core.sv */
// ----------------------------------------------------------------------------
// Pulldown field mapper core
// A picture passes the input register, then the drain's batch register, before its
// first write is offered. Throughput: one picture per cycle while out_ready is high;
// a picture with 2 or 3 writes holds back the next until the output port takes them.
// Reset: synchronous active-low rst_n clears all counters, flags and field_mode.
// ----------------------------------------------------------------------------
module pulldown_field_mapper_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pfm_pkg::pfm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pfm_pkg::pfm_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_data
);
  import pfm_pkg::*;

  // Input register: one picture waits here while its writes are worked out.
  pfm_in_t    item_r;
  logic       item_valid_r;

  // Mapper state, advanced once per picture when its batch is committed.
  pfm_state_t st_r;
  pfm_state_t st_nxt;
  logic [1:0] field_mode_r;

  pfm_batch_t batch;
  logic       drain_free;
  logic       adv_fire;

  // A picture retires from the input register once its writes can be handed
  // to the drain. A picture that produces no writes (a dropped film frame)
  // only updates the state, so it never waits on the output side.
  assign adv_fire = item_valid_r && ((batch.count == 2'd0) || drain_free);
  assign in_ready = !item_valid_r || adv_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
  end

  // The user must write configuration only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_mode_r <= MODE_NORMAL;
    end else if (cfg_we) begin
      field_mode_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv_fire) begin
      st_r <= st_nxt;
    end
  end

  pfm_step u_step (
    .item       (item_r),
    .st         (st_r),
    .field_mode (field_mode_r),
    .st_nxt     (st_nxt),
    .batch      (batch)
  );

  pfm_drain u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv_fire && (batch.count != 2'd0)),
    .batch_in  (batch),
    .free      (drain_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* design/pfm_checker.sv */
// ----------------------------------------------------------------------------
// Pulldown field mapper checker
// Port-level checks on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`include "pulldown_field_mapper_core_macros.svh"

module pfm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input pfm_pkg::pfm_out_t out_data
);
  import pfm_pkg::*;

  // A stalled write transaction holds its payload.
  `PFM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // Writes of one picture follow each other without a gap.
  `PFM_ASSERT_NEXT(a_batch_gapless, clk, rst_n, out_valid && out_ready && !out_data.last, out_valid)

  // Every write of one picture names the same source, overflow flag and first-field order.
  `PFM_ASSERT_NEXT(a_batch_common, clk, rst_n, out_valid && out_ready && !out_data.last, (out_data.source_picture == $past(out_data.source_picture)) && (out_data.overflow == $past(out_data.overflow)) && (out_data.first_field_order == $past(out_data.first_field_order)))

  // Every write touches at least one field.
  `PFM_ASSERT_NOW(a_some_field, clk, rst_n, out_valid, out_data.write_top || out_data.write_bottom)

endmodule

bind pulldown_field_mapper_core pfm_checker u_pfm_checker (.*);
